// File: hdl/ifa_pkg.sv
// Shared types, codes and character tables of the integer to ASCII formatter.
package ifa_pkg;

    localparam int VALUE_W        = 64;
    localparam int CMD_W          = 3;
    localparam int CHAR_W         = 8;
    localparam int MAX_DIGITS_DEF = 20;
    localparam int PFX_W          = 4;

    // Format commands.
    localparam logic [CMD_W-1:0] CMD_UDEC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SDEC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LHEX = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UHEX = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PTR  = 3'd4;

    // Positions in the prefix text "-0x(nil)".
    localparam logic [PFX_W-1:0] PFX_MINUS = 4'd0;
    localparam logic [PFX_W-1:0] PFX_HEX   = 4'd1;
    localparam logic [PFX_W-1:0] PFX_NIL   = 4'd3;
    localparam logic [PFX_W-1:0] PFX_END   = 4'd8;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CMD_W-1:0]   command;
    } t_in_req;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_out_req;

    // One character of the prefix text.
    function automatic logic [CHAR_W-1:0] prefix_char(input logic [PFX_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            4'd0:    ch = 8'h2D; // '-'
            4'd1:    ch = 8'h30; // '0'
            4'd2:    ch = 8'h78; // 'x'
            4'd3:    ch = 8'h28; // '('
            4'd4:    ch = 8'h6E; // 'n'
            4'd5:    ch = 8'h69; // 'i'
            4'd6:    ch = 8'h6C; // 'l'
            4'd7:    ch = 8'h29; // ')'
            default: ch = 8'h3F;
        endcase
        return ch;
    endfunction

    // ASCII symbol of one digit, in lower or upper case for the letters.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                     input logic       upper);
        logic [CHAR_W-1:0] ch;
        if (d < 4'd10) begin
            ch = 8'h30 + {4'd0, d};
        end else if (upper) begin
            ch = 8'h41 + {4'd0, d - 4'd10};
        end else begin
            ch = 8'h61 + {4'd0, d - 4'd10};
        end
        return ch;
    endfunction

endpackage

// File: hdl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: sequencer, digit conversion and output stage.
//
// Each request carries a 64-bit value and a format command and yields its text one character
// per output request, most significant digit first, with last set on the final character.
// Unused commands (5 to 7) are accepted and yield nothing. One item is handled at a time and
// the input is not ready until its text has been handed to the output register. Decimal
// conversion runs a shift-and-add-3 unit over the value, one bit per cycle, over all 64 bits
// for unsigned and the low 32 bits for signed decimal; hex needs no conversion. Leading zero
// digits are then dropped one per cycle, and each character is sent as soon as the output
// register is free. For an item with digits, dropped digits and digit characters together
// number MAX_DIGITS.
module integer_to_ascii_formatter
    import ifa_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    localparam int DIG_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W = $clog2(VALUE_W + 1);
    localparam int HALF  = VALUE_W / 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SKIP = 3'd2;
    localparam logic [2:0] S_PFX  = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;

    logic [2:0]         r_state,   n_state;
    logic [VALUE_W-1:0] r_bin,     n_bin;
    logic [DIG_W-1:0]   r_digits,  n_digits;
    logic [BIT_W-1:0]   r_bits,    n_bits;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [PFX_W-1:0]   r_pfx_idx, n_pfx_idx;
    logic [PFX_W-1:0]   r_pfx_end, n_pfx_end;
    logic               r_has_dig, n_has_dig;
    logic               r_upper,   n_upper;
    logic               r_out_valid, n_out_valid;
    t_out_req           r_out,     n_out;

    logic [DIG_W-1:0]   w_corr;
    logic [31:0]        w_mag;
    logic               w_neg;
    logic               w_slot_free;
    logic [3:0]         w_top;

    // Add-3 correction of every decimal digit at or above five.
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (r_digits[4*k +: 4] >= 4'd5) begin
                w_corr[4*k +: 4] = r_digits[4*k +: 4] + 4'd3;
            end else begin
                w_corr[4*k +: 4] = r_digits[4*k +: 4];
            end
        end
    end

    // Magnitude of the low word in signed mode.
    assign w_neg = i_in_data.value[31];
    assign w_mag = w_neg ? (~i_in_data.value[31:0] + 32'd1) : i_in_data.value[31:0];

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_top       = r_digits[DIG_W-1 -: 4];

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_digits    = r_digits;
        n_bits      = r_bits;
        n_count     = r_count;
        n_pfx_idx   = r_pfx_idx;
        n_pfx_end   = r_pfx_end;
        n_has_dig   = r_has_dig;
        n_upper     = r_upper;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_count   = CNT_W'(MAX_DIGITS);
                    n_pfx_idx = PFX_MINUS;
                    n_pfx_end = PFX_MINUS;
                    n_has_dig = 1'b1;
                    n_upper   = 1'b0;
                    n_digits  = '0;
                    n_bin     = i_in_data.value;
                    case (i_in_data.command) inside
                        CMD_UDEC: begin
                            n_bits  = BIT_W'(VALUE_W);
                            n_state = S_CONV;
                        end
                        CMD_SDEC: begin
                            n_bin   = {w_mag, (VALUE_W - 32)'(0)};
                            n_bits  = BIT_W'(HALF);
                            n_state = S_CONV;
                            if (w_neg) begin
                                n_pfx_end = PFX_HEX;
                            end
                        end
                        CMD_LHEX, CMD_UHEX: begin
                            n_digits = {(DIG_W - VALUE_W)'(0), i_in_data.value};
                            n_upper  = (i_in_data.command == CMD_UHEX);
                            n_state  = S_SKIP;
                        end
                        CMD_PTR: begin
                            if (i_in_data.value == '0) begin
                                n_pfx_idx = PFX_NIL;
                                n_pfx_end = PFX_END;
                                n_has_dig = 1'b0;
                                n_state   = S_PFX;
                            end else begin
                                n_digits  = {(DIG_W - VALUE_W)'(0), i_in_data.value};
                                n_pfx_idx = PFX_HEX;
                                n_pfx_end = PFX_NIL;
                                n_state   = S_SKIP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // One shift-and-add-3 step per cycle.
            S_CONV: begin
                n_digits = {w_corr[DIG_W-2:0], r_bin[VALUE_W-1]};
                n_bin    = {r_bin[VALUE_W-2:0], 1'b0};
                n_bits   = r_bits - BIT_W'(1);
                if (r_bits == BIT_W'(1)) begin
                    n_state = S_SKIP;
                end
            end

            // Drop leading zero digits, keeping at least one.
            S_SKIP: begin
                if (w_top == 4'd0 && r_count > CNT_W'(1)) begin
                    n_digits = {r_digits[DIG_W-5:0], 4'd0};
                    n_count  = r_count - CNT_W'(1);
                end else if (r_pfx_idx != r_pfx_end) begin
                    n_state = S_PFX;
                end else begin
                    n_state = S_DIG;
                end
            end

            // Prefix characters.
            S_PFX: begin
                if (w_slot_free) begin
                    n_out.character = prefix_char(r_pfx_idx);
                    n_out.last      = !r_has_dig && (r_pfx_idx + PFX_W'(1) == r_pfx_end);
                    n_out_valid     = 1'b1;
                    n_pfx_idx       = r_pfx_idx + PFX_W'(1);
                    if (r_pfx_idx + PFX_W'(1) == r_pfx_end) begin
                        n_state = r_has_dig ? S_DIG : S_IDLE;
                    end
                end
            end

            // Digit characters, most significant first.
            S_DIG: begin
                if (w_slot_free) begin
                    n_out.character = digit_char(w_top, r_upper);
                    n_out.last      = (r_count == CNT_W'(1));
                    n_out_valid     = 1'b1;
                    n_digits        = {r_digits[DIG_W-5:0], 4'd0};
                    n_count         = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bits      <= '0;
            r_count     <= '0;
            r_pfx_idx   <= '0;
            r_pfx_end   <= '0;
            r_has_dig   <= 1'b0;
            r_upper     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bits      <= n_bits;
            r_count     <= n_count;
            r_pfx_idx   <= n_pfx_idx;
            r_pfx_end   <= n_pfx_end;
            r_has_dig   <= n_has_dig;
            r_upper     <= n_upper;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_bin    <= n_bin;
        r_digits <= n_digits;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: dv/tb_integer_to_ascii_formatter.sv
// Testbench of the integer to ASCII formatter, with directed and random requests.
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter;
    import ifa_pkg::*;

    // Commands that the block accepts but ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int TEXT_MAX        = 20;
    localparam int RANDOM_REQUESTS = 330;
    localparam int QUIET_TAIL      = 40;
    localparam int LONG_HOLD       = 300;

    // Works out the text of each accepted request and checks the characters as they come.
    class text_scoreboard;
        t_out_req  expected_chars[$];
        logic [7:0] digit_store[TEXT_MAX];
        int        digit_total;
        int        errors;
        string     lower_syms = "0123456789abcdef";
        string     upper_syms = "0123456789ABCDEF";
        string     nil_text   = "(nil)";

        function void push_char(logic [7:0] ch);
            t_out_req r;
            r.character = ch;
            r.last      = 1'b0;
            expected_chars.push_back(r);
        endfunction

        // Digits are gathered least significant first.
        function void gather_digits(logic [63:0] v, logic [63:0] radix, bit upper);
            logic [3:0] d;
            digit_total = 0;
            if (v == 64'd0) begin
                digit_store[0] = "0";
                digit_total = 1;
                return;
            end
            while (v != 64'd0 && digit_total < TEXT_MAX) begin
                d = 4'(v % radix);
                digit_store[digit_total] = upper ? upper_syms[d] : lower_syms[d];
                v = v / radix;
                digit_total++;
            end
        endfunction

        function void push_digits();
            for (int k = digit_total - 1; k >= 0; k--) begin
                push_char(digit_store[k]);
            end
        endfunction

        function void note_request(t_in_req req);
            logic [31:0] low;
            int          first;
            first = expected_chars.size();
            case (req.command)
                CMD_UDEC: begin
                    gather_digits(req.value, 64'd10, 1'b0);
                    push_digits();
                end
                CMD_SDEC: begin
                    // Only the low word counts; a negative one prints as minus and magnitude.
                    low = req.value[31:0];
                    if (low[31]) begin
                        push_char("-");
                        low = ~low + 32'd1;
                    end
                    gather_digits({32'd0, low}, 64'd10, 1'b0);
                    push_digits();
                end
                CMD_LHEX: begin
                    gather_digits(req.value, 64'd16, 1'b0);
                    push_digits();
                end
                CMD_UHEX: begin
                    gather_digits(req.value, 64'd16, 1'b1);
                    push_digits();
                end
                CMD_PTR: begin
                    if (req.value == 64'd0) begin
                        digit_total = 0;
                        for (int i = 0; i < nil_text.len(); i++) begin
                            push_char(nil_text[i]);
                        end
                    end else begin
                        push_char("0");
                        push_char("x");
                        gather_digits(req.value, 64'd16, 1'b0);
                        push_digits();
                    end
                end
                default: begin
                    // Spare commands give no text.
                end
            endcase
            if (expected_chars.size() > first) begin
                expected_chars[expected_chars.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_char(t_out_req got);
            t_out_req want;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                         $time, got.character, got.last);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.character !== want.character) begin
                $display("%0t: character mismatch: expected 0x%02h, actual 0x%02h",
                         $time, want.character, got.character);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     in_valid;
    logic     in_ready;
    t_in_req  in_data;
    logic     out_valid;
    logic     out_ready;
    t_out_req out_data;

    text_scoreboard sb;
    bit             quiet;
    bit             hold_request;

    integer_to_ascii_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Output side: bursts of ready and stall, the long hold on request, none in the tail.
    initial begin
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // Check every character taken from the block.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            sb.check_char(out_data);
        end
    end

    function automatic t_in_req make_request(logic [63:0] value, logic [CMD_W-1:0] command);
        t_in_req req;
        req.value   = value;
        req.command = command;
        return req;
    endfunction

    // Values of every magnitude, with the edges of the signed word now and then.
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       v = v;
            1:       v = v >> $urandom_range(0, 63);
            2:       v = 64'($urandom_range(0, 255));
            3:       v = {v[63:32], 1'b1, 31'($urandom_range(0, 3))};
            default: v = v >> $urandom_range(32, 63);
        endcase
        return v;
    endfunction

    // Offer one request after an optional gap and wait until it is taken.
    task automatic send_request(t_in_req req, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
        sb.note_request(req);
    endtask

    initial begin
        t_in_req          directed[$];
        t_in_req          req;
        logic [CMD_W-1:0] cmd;
        int               taken;
        int               gap;

        sb           = new();
        quiet        = 1'b0;
        hold_request = 1'b0;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero and the largest value under every format command.
        directed.push_back(make_request(64'd0, CMD_UDEC));
        directed.push_back(make_request(64'd0, CMD_SDEC));
        directed.push_back(make_request(64'd0, CMD_LHEX));
        directed.push_back(make_request(64'd0, CMD_UHEX));
        directed.push_back(make_request(64'd0, CMD_PTR));
        directed.push_back(make_request('1, CMD_UDEC));
        directed.push_back(make_request('1, CMD_SDEC));
        directed.push_back(make_request('1, CMD_LHEX));
        directed.push_back(make_request('1, CMD_UHEX));
        directed.push_back(make_request('1, CMD_PTR));
        // Signed edges, and upper bits that signed mode must ignore.
        directed.push_back(make_request(64'h0000_0000_8000_0000, CMD_SDEC));
        directed.push_back(make_request(64'h0000_0000_7FFF_FFFF, CMD_SDEC));
        directed.push_back(make_request(64'hDEAD_BEEF_0000_0123, CMD_SDEC));
        directed.push_back(make_request(64'h0000_0001_FFFF_FFFE, CMD_SDEC));
        // Decimal digit counts at their edges.
        directed.push_back(make_request(64'd10000000000000000000, CMD_UDEC));
        directed.push_back(make_request(64'd9, CMD_UDEC));
        directed.push_back(make_request(64'd10, CMD_UDEC));
        // Letter case and pointer text.
        directed.push_back(make_request(64'h0000_0000_00AB_CDEF, CMD_UHEX));
        directed.push_back(make_request(64'hFEDC_BA98_7654_3210, CMD_LHEX));
        directed.push_back(make_request(64'd1, CMD_PTR));
        directed.push_back(make_request(64'h1234_5678_9ABC_DEF0, CMD_PTR));
        // Spare commands give nothing.
        directed.push_back(make_request(64'd0, CMD_SPARE_5));
        directed.push_back(make_request('1, CMD_SPARE_6));
        directed.push_back(make_request(64'd42, CMD_SPARE_7));
        foreach (directed[i]) begin
            send_request(directed[i], 0);
        end

        // Random requests; spare commands do not count towards the total.
        taken = 0;
        while (taken < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 19) == 0) begin
                cmd = CMD_SPARE_5 + 3'($urandom_range(0, 2));
            end else begin
                cmd = 3'($urandom_range(CMD_UDEC, CMD_PTR));
            end
            req = make_request(pick_value(), cmd);
            if (taken == 100 && cmd <= CMD_PTR) begin
                hold_request = 1'b1;
            end
            if (taken == RANDOM_REQUESTS - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
            send_request(req, gap);
            if (cmd <= CMD_PTR) begin
                taken++;
            end
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray character.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
